>>> hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hdl/smts_pkg.sv
`default_nettype none
package smts_pkg;
  localparam logic [1:0] CmdTick   = 2'd0;
  localparam logic [1:0] CmdStart  = 2'd1;
  localparam logic [1:0] CmdStop   = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  timer_id;
    logic [23:0] interval;
    logic [15:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [3:0] fired_timer;
    logic       last_fired;
  } out_item_t;

  // saturating subtract of an unsigned amount from a signed countdown
  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a, logic [15:0] b);
    logic signed [32:0] v;
    v = 33'(a) - $signed({17'd0, b});
    if (v < -33'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

>>> hdl/sorted_multi_timer_scheduler.sv
// Sorted periodic timer queue.
// Input beats (in_valid_i/in_ready_o) carry one command: tick, start or stop.
// Output beats (out_valid_o/out_ready_i) carry one fired timer each, in firing
// order; last_fired marks the final beat of a tick. Start and stop emit none.
// One sequencer with one shared comparator walks the order list; countdown,
// period and order list sit in RAMs with one registered read port each.
// Steps of each command once it is accepted in idle:
//   stop:              find, then remove
//   start, idle timer: sorted walk, then shift up
//   start, running:    find, neighbor checks, remove, reinsert
//   tick:              decrement pass and first head check, then one remove,
//                      reinsert and head check per fired timer while the output is ready.
// A beat is offered once its timer is reinserted and the next head is checked.
// in_ready_o is high only in idle, so one command runs at a time.
// A stalled output holds the sequencer in place; nothing is lost.
// Reset clears the list length and the per-timer active flags; RAM contents
// are only read for listed timers, so no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module sorted_multi_timer_scheduler #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire smts_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output smts_pkg::out_item_t       out_data_o
);
  localparam int IW = $clog2(NUM_TIMERS);
  localparam int LW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [4:0] {
    SIdle, SStart, SFindRd, SFindCmp, SNbrRd, SNbrId, SNbrCmp, SRemRd, SRemWr,
    SInsRd, SInsId, SInsCmp, SShRd, SShWr, SPut, SDecRd, SDecId, SDecWr,
    SHeadRd, SHeadId, SHeadChk, SOut
  } state_e;

  typedef enum logic [1:0] {OpStart, OpStop, OpFire} op_e;

  state_e state_q;
  op_e    op_q;
  logic [23:0] iv_q;
  logic [15:0] el_q;
  logic [NUM_TIMERS-1:0] act_q;
  logic [LW-1:0] len_q;
  logic [LW-1:0] p_q, pos_q;
  logic [IW-1:0] id_q;
  logic signed [31:0] key_q;
  logic nbr_q, pend_q;
  logic [3:0] fired_q;
  logic last_q;

  // RAM ports
  logic ol_we, cd_we, pr_we;
  logic [IW-1:0] ol_wa, ol_ra, cd_wa, cd_ra, pr_wa, pr_ra;
  logic [IW-1:0] ol_wd, ol_rd;
  logic [31:0] cd_wd, cd_rd;
  logic [23:0] pr_wd, pr_rd;

  smts_ram #(.Width(IW), .Depth(NUM_TIMERS)) u_order (
    .clk_i, .we_i(ol_we), .waddr_i(ol_wa), .wdata_i(ol_wd), .raddr_i(ol_ra),
    .rdata_o(ol_rd));
  smts_ram #(.Width(32), .Depth(NUM_TIMERS)) u_cd (
    .clk_i, .we_i(cd_we), .waddr_i(cd_wa), .wdata_i(cd_wd), .raddr_i(cd_ra),
    .rdata_o(cd_rd));
  smts_ram #(.Width(24), .Depth(NUM_TIMERS)) u_per (
    .clk_i, .we_i(pr_we), .waddr_i(pr_wa), .wdata_i(pr_wd), .raddr_i(pr_ra),
    .rdata_o(pr_rd));

  logic signed [31:0] cd_val;
  assign cd_val = $signed(cd_rd);

  logic [23:0] per_new;
  assign per_new = (iv_q == 24'd0) ? 24'd1 : iv_q;

  logic in_ok;
  assign in_ok = {28'd0, in_data_i.timer_id} < 32'(NUM_TIMERS);
  logic [IW-1:0] in_id;
  assign in_id = IW'(in_data_i.timer_id);

  logic [IW-1:0] p_ix, pos_ix;
  assign p_ix = p_q[IW-1:0];
  assign pos_ix = pos_q[IW-1:0];

  // shared comparator
  logic signed [31:0] cmp_a, cmp_b;
  logic signed [32:0] cmp_diff;
  logic cmp_le, cmp_lt;
  assign cmp_diff = 33'(cmp_a) - 33'(cmp_b);
  assign cmp_lt = cmp_diff[32];
  assign cmp_le = cmp_lt || (cmp_diff == '0);

  always_comb begin
    ol_we = 1'b0; ol_wa = p_ix; ol_wd = ol_rd; ol_ra = p_ix;
    cd_we = 1'b0; cd_wa = id_q; cd_wd = {8'd0, pr_rd}; cd_ra = ol_rd;
    pr_we = 1'b0; pr_wa = id_q; pr_wd = per_new; pr_ra = ol_rd;
    cmp_a = cd_val; cmp_b = key_q;
    unique case (state_q)
      SStart: begin
        cd_we = 1'b1; cd_wd = {8'd0, iv_q};
        pr_we = 1'b1;
      end
      SNbrRd: ol_ra = nbr_q ? IW'(pos_q - LW'(1)) : IW'(pos_q + LW'(1));
      // previous neighbor is broken when key < its countdown
      SNbrCmp: if (nbr_q) begin cmp_a = key_q; cmp_b = cd_val; end
      SRemRd: ol_ra = IW'(p_q + LW'(1));
      SRemWr: ol_we = 1'b1;
      SShRd: ol_ra = IW'(p_q - LW'(1));
      SShWr: ol_we = 1'b1;
      SPut: begin ol_we = 1'b1; ol_wa = pos_ix; ol_wd = id_q; end
      SDecWr: begin
        cd_we = 1'b1;
        cd_wd = smts_pkg::sat_sub(cd_val, el_q);
      end
      SHeadRd: ol_ra = '0;
      SHeadChk: begin
        // reload from period when the head fires
        cmp_b = 32'sd0;
        cd_we = !pend_q && cmp_le;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; op_q <= OpStart; act_q <= '0; len_q <= '0;
      p_q <= '0; pos_q <= '0; id_q <= '0; key_q <= '0; nbr_q <= 1'b0;
      pend_q <= 1'b0; fired_q <= '0; last_q <= 1'b0;
      iv_q <= '0; el_q <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) begin
          iv_q <= in_data_i.interval; el_q <= in_data_i.elapsed;
          id_q <= in_id; p_q <= '0; pend_q <= 1'b0;
          unique case (in_data_i.command)
            smts_pkg::CmdTick:  state_q <= SDecRd;
            smts_pkg::CmdStart: if (in_ok) state_q <= SStart;
            smts_pkg::CmdStop:  if (in_ok && act_q[in_id]) begin
              op_q <= OpStop; state_q <= SFindRd;
            end
            default: ;
          endcase
        end
        SStart: begin
          key_q <= {8'd0, iv_q}; op_q <= OpStart; p_q <= '0;
          if (!act_q[id_q]) begin
            act_q[id_q] <= 1'b1; state_q <= SInsRd;
          end else begin
            state_q <= SFindRd;
          end
        end
        SFindRd: state_q <= SFindCmp;
        SFindCmp: begin
          if (ol_rd == id_q) begin
            pos_q <= p_q;
            if (op_q == OpStop) state_q <= SRemRd;
            else if (p_q + LW'(1) < len_q) begin nbr_q <= 1'b0; state_q <= SNbrRd; end
            else if (p_q != '0) begin nbr_q <= 1'b1; state_q <= SNbrRd; end
            else state_q <= SIdle;
          end else begin
            p_q <= p_q + LW'(1); state_q <= SFindRd;
          end
        end
        SNbrRd: state_q <= SNbrId;
        SNbrId: state_q <= SNbrCmp;
        SNbrCmp: begin
          if (!nbr_q && !cmp_lt && pos_q != '0) begin
            nbr_q <= 1'b1; state_q <= SNbrRd;
          end else if (cmp_lt) begin
            p_q <= pos_q; state_q <= SRemRd;
          end else state_q <= SIdle;
        end
        SRemRd: begin
          if (p_q + LW'(1) < len_q) state_q <= SRemWr;
          else begin
            len_q <= len_q - LW'(1); p_q <= '0;
            if (op_q == OpStop) begin act_q[id_q] <= 1'b0; state_q <= SIdle; end
            else state_q <= SInsRd;
          end
        end
        SRemWr: begin p_q <= p_q + LW'(1); state_q <= SRemRd; end
        SInsRd: begin
          if (p_q < len_q) state_q <= SInsId;
          else begin pos_q <= p_q; state_q <= SShRd; end
        end
        SInsId: state_q <= SInsCmp;
        SInsCmp: begin
          // ties stay ahead of the new entry
          if (cmp_le) begin p_q <= p_q + LW'(1); state_q <= SInsRd; end
          else begin pos_q <= p_q; p_q <= len_q; state_q <= SShRd; end
        end
        SShRd: state_q <= (p_q > pos_q) ? SShWr : SPut;
        SShWr: begin p_q <= p_q - LW'(1); state_q <= SShRd; end
        SPut: begin
          len_q <= len_q + LW'(1);
          if (op_q == OpFire) begin pend_q <= 1'b1; state_q <= SHeadRd; end
          else state_q <= SIdle;
        end
        SDecRd: state_q <= (p_q < len_q) ? SDecId : SHeadRd;
        SDecId: begin id_q <= ol_rd; state_q <= SDecWr; end
        SDecWr: begin p_q <= p_q + LW'(1); state_q <= SDecRd; end
        SHeadRd: state_q <= (len_q == '0) ? SIdle : SHeadId;
        SHeadId: begin id_q <= ol_rd; state_q <= SHeadChk; end
        SHeadChk: begin
          if (pend_q) begin
            // the held beat is last unless the new head fires too
            last_q <= !cmp_le; state_q <= SOut;
          end else if (cmp_le) begin
            key_q <= {8'd0, pr_rd}; fired_q <= 4'(id_q); op_q <= OpFire;
            pos_q <= '0; p_q <= '0; state_q <= SRemRd;
          end else state_q <= SIdle;
        end
        SOut: if (out_ready_i) begin
          pend_q <= 1'b0;
          state_q <= last_q ? SIdle : SHeadRd;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o = state_q == SIdle;
  assign out_valid_o = state_q == SOut;
  assign out_data_o = '{fired_timer: fired_q, last_fired: last_q};

  `ASSERT_NEVER(a_len, clk_i, rst_ni, len_q > LW'(NUM_TIMERS), "list overflow")
  `ASSERT_NEVER(a_hs, clk_i, rst_ni, in_ready_o && out_valid_o, "busy overlap")
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "beat dropped")
  `ASSERT_IMPL(a_out_len, clk_i, rst_ni, out_valid_o |-> len_q != '0, "beat with empty list")
endmodule
`default_nettype wire

>>> hdl/smts_ram.sv
`default_nettype none
module smts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
